[src/npt_pkg.sv]
// ----------------------------------------------------------------------------
// npt_pkg
// shared types and constants for the name and punctuation tokenizer
// ----------------------------------------------------------------------------
package npt_pkg;

   localparam int LINE_BITS   = 24;
   localparam int COLUMN_BITS = 16;

   typedef enum logic [1:0] {
      KIND_NAME  = 2'd0,
      KIND_PUNCT = 2'd1,
      KIND_END   = 2'd2
   } token_kind_type;

   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_VTAB       = 8'h0B;
   localparam logic [7:0] CHAR_FORMFEED   = 8'h0C;
   localparam logic [7:0] CHAR_RETURN     = 8'h0D;

   typedef struct packed {
      token_kind_type         kind;
      logic [7:0]             char_val;
      logic                   last;
      logic [LINE_BITS-1:0]   line;
      logic [COLUMN_BITS-1:0] column;
   } result_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_NEWLINE) || (c == CHAR_TAB) ||
             (c == CHAR_VTAB) || (c == CHAR_FORMFEED) || (c == CHAR_RETURN);
   endfunction

   function automatic logic is_name_char(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h30 && c <= 8'h39) || (c == CHAR_UNDERSCORE);
   endfunction

endpackage

[src/npt_lexer.sv]
// ----------------------------------------------------------------------------
// npt_lexer
// lexer state and the per-byte step logic, up to two results per request
// ----------------------------------------------------------------------------
module npt_lexer (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [7:0]          source_byte,
   input  logic                end_of_input,
   output logic [1:0]          num_results,
   output npt_pkg::result_type res0,
   output npt_pkg::result_type res1
);
   import npt_pkg::*;

   localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;
   localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = '1;

   logic                   inside_ff, inside_in;
   logic [7:0]             held_ff, held_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, line_adv;
   logic [COLUMN_BITS-1:0] col_ff, col_in, col_adv;
   logic [COLUMN_BITS-1:0] start_ff, start_in;
   logic                   ended_ff, ended_in;
   logic                   name_c, space_c;
   result_type             held_res, punct_res, end_res;

   always_comb begin
      name_c  = is_name_char(source_byte);
      space_c = is_space(source_byte);
      line_adv = line_ff;
      col_adv  = col_ff;
      if (source_byte == CHAR_NEWLINE) begin
         if (line_ff != LINE_MAX) line_adv = line_ff + 1'b1;
         col_adv = '0;
      end else if (col_ff != COLUMN_MAX) begin
         col_adv = col_ff + 1'b1;
      end
   end

   always_comb begin
      held_res.kind     = KIND_NAME;
      held_res.char_val = held_ff;
      held_res.last     = 1'b1;
      held_res.line     = line_ff;
      held_res.column   = start_ff;

      punct_res.kind     = KIND_PUNCT;
      punct_res.char_val = source_byte;
      punct_res.last     = 1'b0;
      punct_res.line     = line_adv;
      punct_res.column   = col_adv;

      end_res.kind     = KIND_END;
      end_res.char_val = '0;
      end_res.last     = 1'b0;
      end_res.line     = line_ff;
      end_res.column   = col_ff;
   end

   always_comb begin
      num_results = 2'd0;
      res0        = held_res;
      res1        = end_res;
      inside_in   = inside_ff;
      held_in     = held_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      start_in    = start_ff;
      ended_in    = ended_ff;
      if (ended_ff) begin
         num_results = 2'd0;
      end else if (end_of_input) begin
         ended_in  = 1'b1;
         inside_in = 1'b0;
         if (inside_ff) begin
            num_results = 2'd2;
         end else begin
            num_results = 2'd1;
            res0        = end_res;
         end
      end else if (inside_ff && name_c) begin
         num_results   = 2'd1;
         res0.last     = 1'b0;
         held_in       = source_byte;
         line_in       = line_adv;
         col_in        = col_adv;
      end else begin
         line_in   = line_adv;
         col_in    = col_adv;
         inside_in = 1'b0;
         if (space_c) begin
            num_results = {1'b0, inside_ff};
         end else if (name_c) begin
            num_results = {1'b0, inside_ff};
            inside_in   = 1'b1;
            held_in     = source_byte;
            start_in    = col_adv;
         end else if (inside_ff) begin
            num_results = 2'd2;
            res1        = punct_res;
         end else begin
            num_results = 2'd1;
            res0        = punct_res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         held_ff   <= '0;
         line_ff   <= LINE_BITS'(1);
         col_ff    <= '0;
         start_ff  <= '0;
         ended_ff  <= 1'b0;
      end else if (fire) begin
         inside_ff <= inside_in;
         held_ff   <= held_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         start_ff  <= start_in;
         ended_ff  <= ended_in;
      end
   end

endmodule

[src/npt_rsp_fifo.sv]
// ----------------------------------------------------------------------------
// npt_rsp_fifo
// two-entry result queue, takes up to two results per cycle, gives one
// ----------------------------------------------------------------------------
module npt_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          push_count,
   input  npt_pkg::result_type push0,
   input  npt_pkg::result_type push1,
   output logic [1:0]          free_count,
   output logic                out_valid,
   input  logic                out_ready,
   output npt_pkg::result_type out_data
);
   import npt_pkg::*;

   result_type  slot_ff [2];
   logic        wr_ff, wr_in;
   logic        rd_ff, rd_in;
   logic [1:0]  count_ff, count_in;
   logic        pop;

   assign out_valid  = (count_ff != 2'd0);
   assign pop        = out_valid && out_ready;
   assign out_data   = slot_ff[rd_ff];
   assign free_count = 2'd2 - count_ff + {1'b0, pop};

   always_comb begin
      rd_in    = rd_ff ^ pop;
      wr_in    = wr_ff ^ push_count[0];
      count_in = count_ff - {1'b0, pop} + push_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) slot_ff[wr_ff] <= push0;
      if (push_count == 2'd2) slot_ff[~wr_ff] <= push1;
   end

endmodule

[src/name_punct_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// name_punct_tokenizer_top
// name and punctuation tokenizer, one source byte per request
// ----------------------------------------------------------------------------
// Takes one byte (or an end mark) per cycle into an input register unless
// stalled, steps the lexer state and queues the results in a two-entry output
// queue. Sustained rate is one request per cycle while the consumer is ready;
// a request with two results (a name closed by punctuation, or the end mark
// after a name) sends them one after the other through the single result
// port, so such requests stall the input once the queue holds a backlog.
// Line and column start at 1 and saturate; requests after the end mark
// produce nothing until reset.
// ----------------------------------------------------------------------------
module name_punct_tokenizer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_source_byte,
   input  logic                                req_end_of_input,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_token_kind,
   output logic [7:0]                          rsp_token_char,
   output logic                                rsp_name_last,
   output logic [npt_pkg::LINE_BITS-1:0]       rsp_token_line,
   output logic [npt_pkg::COLUMN_BITS-1:0]     rsp_token_col
);
   import npt_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eoi_ff;
   logic       fire;
   logic [1:0] num_results, free_count, push_count;
   result_type res0, res1, out_data;

   npt_lexer u_lexer (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .source_byte  (in_byte_ff),
      .end_of_input (in_eoi_ff),
      .num_results  (num_results),
      .res0         (res0),
      .res1         (res1)
   );

   assign fire       = in_valid_ff && (num_results <= free_count);
   assign push_count = fire ? num_results : 2'd0;
   assign req_ready  = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_source_byte;
         in_eoi_ff  <= req_end_of_input;
      end
   end

   npt_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (res0),
      .push1      (res1),
      .free_count (free_count),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_data)
   );

   assign rsp_token_kind   = out_data.kind;
   assign rsp_token_char   = out_data.char_val;
   assign rsp_name_last    = out_data.last;
   assign rsp_token_line   = out_data.line;
   assign rsp_token_col    = out_data.column;

endmodule
